/* design/gnh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Geographic next-hop table package
// Field widths, codes and transaction types shared by the table and its units.
// ----------------------------------------------------------------------------
package gnh_pkg;

	localparam int NEIGHBORS_DEFAULT = 32;
	localparam int COORD_BITS        = 24;
	localparam int TIME_BITS         = 48;
	localparam int ID_BITS           = 16;
	localparam int CMD_BITS          = 2;
	localparam int METHOD_BITS       = 2;
	localparam int STATUS_BITS       = 3;
	localparam int COUNT_BITS        = 6;
	localparam int ADDR_BITS         = 6;
	localparam int DATA_BITS         = 64;

	localparam logic [CMD_BITS-1:0] CMD_HELLO = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ROUTE = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_PURGE = 2'd2;

	localparam logic [METHOD_BITS-1:0] METHOD_GREEDY  = 2'd0;
	localparam logic [METHOD_BITS-1:0] METHOD_NFP     = 2'd1;
	localparam logic [METHOD_BITS-1:0] METHOD_MFR     = 2'd2;
	localparam logic [METHOD_BITS-1:0] METHOD_COMPASS = 2'd3;

	localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 3'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_UPDATED  = 3'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 3'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_FOUND    = 3'd3;
	localparam logic [STATUS_BITS-1:0] STATUS_NO_ROUTE = 3'd4;
	localparam logic [STATUS_BITS-1:0] STATUS_PURGED   = 3'd5;

	localparam logic [2:0] REG_METHOD = 3'd0;
	localparam logic [2:0] REG_EXPIRY = 3'd1;
	localparam logic [2:0] REG_SELF_X = 3'd2;
	localparam logic [2:0] REG_SELF_Y = 3'd3;
	localparam logic [2:0] REG_SELF_Z = 3'd4;

	localparam logic [TIME_BITS-1:0]  EXPIRY_RESET = 48'd2500000000;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 6'd63;

	typedef struct packed {
		logic [CMD_BITS-1:0]          command;
		logic [TIME_BITS-1:0]         now;
		logic [ID_BITS-1:0]           neighbor_id;
		logic signed [COORD_BITS-1:0] nbr_x;
		logic signed [COORD_BITS-1:0] nbr_y;
		logic signed [COORD_BITS-1:0] nbr_z;
		logic signed [COORD_BITS-1:0] dest_x;
		logic signed [COORD_BITS-1:0] dest_y;
		logic signed [COORD_BITS-1:0] dest_z;
	} gnh_req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [ID_BITS-1:0]     next_hop_id;
		logic [COUNT_BITS-1:0]  removed_count;
	} gnh_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gnh_mul_stat_t;

endpackage
`default_nettype wire

/* design/gnh_serial_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle, done pulse.
// ----------------------------------------------------------------------------
module gnh_serial_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [AW-1:0]          a,
	input  logic [BW-1:0]          b,
	output logic [AW+BW-1:0]       product,
	output gnh_pkg::gnh_mul_stat_t stat
);
	import gnh_pkg::*;

	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW+BW-1:0] a_q;
	logic [BW-1:0]    b_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	gnh_mul_stat_t    stat_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {{BW{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign stat_w  = '{busy: busy_q, done: done_q};
	assign stat    = stat_w;
	assign product = acc_q;

endmodule
`default_nettype wire

/* design/geographic_next_hop_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Geographic next-hop table
// Neighbor table in one synchronous memory, hello/purge scans and next-hop
// selection by greedy, NFP, MFR or compass over the live neighbors.
// ----------------------------------------------------------------------------
// Hello and purge: one slot read per cycle over all NEIGHBORS slots.
// Route query: a setup pass, then each live slot goes through the shared
// signed multiplier (nine products per slot).
// Compass ties of equal nonzero sign add four serial multiplies through
// the shift-add unit.
// Reset empties the table at once through per-slot valid flops; registers
// take their reset values and the block is ready in the first cycle.
module geographic_next_hop_table_top #(
	parameter int NEIGHBORS = gnh_pkg::NEIGHBORS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  gnh_pkg::gnh_req_t                req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output gnh_pkg::gnh_rsp_t                rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gnh_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [gnh_pkg::DATA_BITS-1:0]    pwdata,
	output logic [gnh_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready
);
	import gnh_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam int KW = $clog2(NEIGHBORS + 1);
	localparam int EW = CB + 1;
	localparam int SW = 2 * CB + 2;
	localparam int DW = 2 * CB + 3;
	localparam int AW = 2 * SW;
	localparam int BW = SW;
	localparam int PW = AW + BW;
	localparam logic [KW-1:0] LAST_K = KW'(NEIGHBORS);

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic [TIME_BITS-1:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_WRITE, S_PRE, S_MUL, S_DRAIN, S_CHECK,
		S_NEXT, S_LOAD, S_DEC, S_CMUL, S_CCMP, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		ST_FX, ST_FY, ST_FZ, ST_EX, ST_EY, ST_EZ,
		ST_GX, ST_GY, ST_GZ, ST_DX, ST_DY, ST_DZ
	} step_t;

	typedef enum logic [1:0] {
		RANK_NEG, RANK_ZERO, RANK_POS
	} rank_t;

	function automatic logic signed [EW-1:0] ext(input logic signed [CB-1:0] v);
		ext = {v[CB-1], v};
	endfunction

	// configuration
	logic [METHOD_BITS-1:0] method_q;
	logic [TIME_BITS-1:0]   expiry_q;
	logic signed [CB-1:0]   self_x_q, self_y_q, self_z_q;

	// table
	entry_t               entry_mem [NEIGHBORS];
	entry_t               rd_q;
	logic [NEIGHBORS-1:0] valid_q;
	logic                 mem_we, mem_re;
	logic [IW-1:0]        mem_waddr;
	entry_t               mem_wdata;

	// control
	state_t   state_q;
	gnh_req_t req_q;
	logic [KW-1:0] k_q;
	logic          chk_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q, free_found_q;
	logic [IW-1:0] match_q, free_q;
	logic [COUNT_BITS-1:0]  removed_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [ID_BITS-1:0]     hop_q, cur_id_q;
	logic          have_q, pre_q;
	gnh_rsp_t      rsp_q;
	logic          rsp_valid_q;

	// selection state
	logic [DW-1:0] best_q;
	logic [SW-1:0] ref_q, bmag_q, bpw_q, cur_m_q;
	rank_t         brank_q, cur_rank_q;

	// products and sums
	step_t                step_q, tag_s1;
	logic                 acc_s1;
	logic signed [EW-1:0] fx_q, fy_q, fz_q, ex_q, ey_q, ez_q, gx_q, gy_q, gz_q;
	logic signed [EW-1:0] opa, opb;
	logic signed [SW-1:0] prod_s1;
	logic [SW-1:0]        sq;
	logic signed [DW-1:0] pe;
	logic [SW-1:0]        d2_q, d2xy_q, ns_q, pw_q, nd_q;
	logic signed [DW-1:0] dot_q, dot2_q;

	// compass cross products
	logic [1:0]    cstep_q;
	logic          mstart_q;
	logic [AW-1:0] t_q, mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] x_q, y_q, mul_p;
	gnh_mul_stat_t mul_stat;

	// decision logic
	logic [TIME_BITS-1:0] age;
	logic                 stale_rd;
	logic signed [DW:0]   mfr_diff;
	logic [DW-1:0]        metric;
	logic                 skip, lt, eq, need_mul, take;
	rank_t                rank;
	logic [SW-1:0]        mag;
	logic                 c_lt, c_eq, c_take;
	logic                 cfg_wr;

	assign pready    = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_GREEDY;
			expiry_q <= EXPIRY_RESET;
			self_x_q <= '0;
			self_y_q <= '0;
			self_z_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_METHOD: method_q <= pwdata[METHOD_BITS-1:0];
				REG_EXPIRY: expiry_q <= pwdata[TIME_BITS-1:0];
				REG_SELF_X: self_x_q <= pwdata[CB-1:0];
				REG_SELF_Y: self_y_q <= pwdata[CB-1:0];
				REG_SELF_Z: self_z_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_METHOD: prdata = DATA_BITS'(method_q);
			REG_EXPIRY: prdata = DATA_BITS'(expiry_q);
			REG_SELF_X: prdata = DATA_BITS'(signed'(self_x_q));
			REG_SELF_Y: prdata = DATA_BITS'(signed'(self_y_q));
			REG_SELF_Z: prdata = DATA_BITS'(signed'(self_z_q));
			default:    prdata = '0;
		endcase
	end

	// ---------------- table memory ----------------
	assign mem_re = (k_q != LAST_K) &&
		((state_q == S_SCAN) || ((state_q == S_NEXT) && valid_q[k_q[IW-1:0]]));
	assign mem_we    = (state_q == S_WRITE) && (found_q || free_found_q);
	assign mem_waddr = found_q ? match_q : free_q;
	assign mem_wdata = '{id: req_q.neighbor_id, x: req_q.nbr_x, y: req_q.nbr_y,
		z: req_q.nbr_z, stamp: req_q.now};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= entry_mem[k_q[IW-1:0]];
		end
	end

	assign age      = req_q.now - rd_q.stamp;
	assign stale_rd = (expiry_q != '0) && (age >= expiry_q);

	// ---------------- multiplier and sums ----------------
	always_comb begin
		case (step_q)
			ST_FX:   begin opa = fx_q; opb = fx_q; end
			ST_FY:   begin opa = fy_q; opb = fy_q; end
			ST_FZ:   begin opa = fz_q; opb = fz_q; end
			ST_EX:   begin opa = ex_q; opb = ex_q; end
			ST_EY:   begin opa = ey_q; opb = ey_q; end
			ST_EZ:   begin opa = ez_q; opb = ez_q; end
			ST_GX:   begin opa = gx_q; opb = gx_q; end
			ST_GY:   begin opa = gy_q; opb = gy_q; end
			ST_GZ:   begin opa = gz_q; opb = gz_q; end
			ST_DX:   begin opa = ex_q; opb = fx_q; end
			ST_DY:   begin opa = ey_q; opb = fy_q; end
			ST_DZ:   begin opa = ez_q; opb = fz_q; end
			default: begin opa = '0;   opb = '0;   end
		endcase
	end

	assign sq = prod_s1;
	assign pe = {prod_s1[SW-1], prod_s1};

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		if (acc_s1) begin
			case (tag_s1)
				ST_FX: d2_q <= sq;
				ST_FY: begin
					d2_q   <= d2_q + sq;
					d2xy_q <= d2_q + sq;
				end
				ST_FZ: d2_q <= d2_q + sq;
				ST_EX: ns_q <= sq;
				ST_EY: begin
					ns_q <= ns_q + sq;
					pw_q <= ns_q + sq;
				end
				ST_EZ: ns_q <= ns_q + sq;
				ST_GX: nd_q <= sq;
				ST_GY: nd_q <= nd_q + sq;
				ST_GZ: nd_q <= nd_q + sq;
				ST_DX: dot_q <= pe;
				ST_DY: begin
					dot_q  <= dot_q + pe;
					dot2_q <= dot_q + pe;
				end
				ST_DZ: dot_q <= dot_q + pe;
				default: ;
			endcase
		end
	end

	// ---------------- selection ----------------
	always_comb begin
		// one extra bit: d2 minus a negative dot can exceed the range of dot
		mfr_diff = $signed({2'b00, d2_q}) - $signed({dot_q[DW-1], dot_q});
		case (method_q)
			METHOD_GREEDY: metric = DW'(nd_q);
			METHOD_NFP:    metric = DW'(ns_q);
			METHOD_MFR:    metric = mfr_diff[DW] ? DW'(-mfr_diff) : DW'(mfr_diff);
			default:       metric = '0;
		endcase
		if (dot2_q < 0) begin
			rank = RANK_NEG;
			mag  = SW'(-dot2_q);
		end else if (dot2_q == '0) begin
			rank = RANK_ZERO;
			mag  = '0;
		end else begin
			rank = RANK_POS;
			mag  = SW'(dot2_q);
		end
		skip = ((method_q == METHOD_NFP) && (nd_q > d2_q)) ||
			((method_q == METHOD_COMPASS) && (pw_q == '0));
		need_mul = 1'b0;
		if (method_q == METHOD_COMPASS) begin
			if (!have_q) begin
				lt = 1'b1;
				eq = 1'b0;
			end else if (rank != brank_q) begin
				lt = (rank > brank_q);
				eq = 1'b0;
			end else begin
				lt = 1'b0;
				eq = (rank == RANK_ZERO);
				need_mul = (rank != RANK_ZERO);
			end
		end else begin
			lt = (metric < best_q);
			eq = (metric == best_q);
		end
		take = !skip && (lt || (eq && (nd_q < ref_q)));

		// equal-sign compass tie: compare m^2 * bpw against bmag^2 * pw
		c_lt   = (cur_rank_q == RANK_POS) ? (x_q > y_q) : (x_q < y_q);
		c_eq   = (x_q == y_q);
		c_take = c_lt || (c_eq && (nd_q < ref_q));
	end

	always_comb begin
		case (cstep_q)
			2'd0:    begin mul_a = AW'(cur_m_q); mul_b = cur_m_q; end
			2'd1:    begin mul_a = t_q;          mul_b = bpw_q;   end
			2'd2:    begin mul_a = AW'(bmag_q);  mul_b = bmag_q;  end
			default: begin mul_a = t_q;          mul_b = pw_q;    end
		endcase
	end

	gnh_serial_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.a      (mul_a),
		.b      (mul_b),
		.product(mul_p),
		.stat   (mul_stat)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_CMUL && mul_stat.done) begin
			case (cstep_q)
				2'd1:    x_q <= mul_p;
				2'd3:    y_q <= mul_p;
				default: t_q <= mul_p[AW-1:0];
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			rsp_valid_q  <= 1'b0;
			k_q          <= '0;
			chk_s1       <= 1'b0;
			acc_s1       <= 1'b0;
			mstart_q     <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			have_q       <= 1'b0;
			pre_q        <= 1'b0;
			step_q       <= ST_FX;
			cstep_q      <= '0;
		end else begin
			acc_s1   <= (state_q == S_MUL);
			tag_s1   <= step_q;
			// launch a serial multiply from the decision or after each but the last ends
			mstart_q <= ((state_q == S_DEC) && !skip && need_mul) ||
				((state_q == S_CMUL) && mul_stat.done && (cstep_q != 2'd3));
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q        <= req;
						k_q          <= '0;
						chk_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= '0;
						hop_q        <= '0;
						if (req.command == CMD_HELLO || req.command == CMD_PURGE) begin
							state_q <= S_SCAN;
						end else if (req.command == CMD_ROUTE) begin
							state_q <= S_PRE;
						end
					end
				end
				S_SCAN: begin
					if (k_q != LAST_K) begin
						chk_s1 <= 1'b1;
						idx_s1 <= k_q[IW-1:0];
						k_q    <= k_q + KW'(1);
						if (!valid_q[k_q[IW-1:0]] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= k_q[IW-1:0];
						end
					end else begin
						chk_s1 <= 1'b0;
					end
					if (chk_s1 && valid_q[idx_s1]) begin
						if (req_q.command == CMD_HELLO) begin
							if (rd_q.id == req_q.neighbor_id && !found_q) begin
								found_q <= 1'b1;
								match_q <= idx_s1;
							end
						end else if (stale_rd) begin
							valid_q[idx_s1] <= 1'b0;
							if (removed_q != COUNT_MAX) begin
								removed_q <= removed_q + COUNT_BITS'(1);
							end
						end
					end
					if (k_q == LAST_K && !chk_s1) begin
						if (req_q.command == CMD_HELLO) begin
							state_q <= S_WRITE;
						end else begin
							status_q <= STATUS_PURGED;
							state_q  <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					if (found_q) begin
						status_q <= STATUS_UPDATED;
					end else if (free_found_q) begin
						status_q <= STATUS_INSERTED;
					end else begin
						status_q <= STATUS_FULL;
					end
					if (mem_we) begin
						valid_q[mem_waddr] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_PRE: begin
					fx_q    <= ext(req_q.dest_x) - ext(self_x_q);
					fy_q    <= ext(req_q.dest_y) - ext(self_y_q);
					fz_q    <= ext(req_q.dest_z) - ext(self_z_q);
					step_q  <= ST_FX;
					pre_q   <= 1'b1;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_t'(step_q + 4'd1);
					if (step_q == (pre_q ? ST_FZ : ST_DZ)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= pre_q ? S_CHECK : S_DEC;
				end
				S_CHECK: begin
					have_q  <= 1'b0;
					best_q  <= DW'(d2_q);
					ref_q   <= d2_q;
					brank_q <= RANK_ZERO;
					k_q     <= '0;
					if ((method_q == METHOD_MFR && d2_q == '0) ||
						(method_q == METHOD_COMPASS && d2xy_q == '0)) begin
						status_q <= STATUS_NO_ROUTE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (k_q == LAST_K) begin
						status_q <= have_q ? STATUS_FOUND : STATUS_NO_ROUTE;
						state_q  <= S_DONE;
					end else if (valid_q[k_q[IW-1:0]]) begin
						state_q <= S_LOAD;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_LOAD: begin
					if (stale_rd) begin
						k_q     <= k_q + KW'(1);
						state_q <= S_NEXT;
					end else begin
						ex_q     <= ext(rd_q.x) - ext(self_x_q);
						ey_q     <= ext(rd_q.y) - ext(self_y_q);
						ez_q     <= ext(rd_q.z) - ext(self_z_q);
						gx_q     <= ext(rd_q.x) - ext(req_q.dest_x);
						gy_q     <= ext(rd_q.y) - ext(req_q.dest_y);
						gz_q     <= ext(rd_q.z) - ext(req_q.dest_z);
						cur_id_q <= rd_q.id;
						step_q   <= ST_EX;
						pre_q    <= 1'b0;
						state_q  <= S_MUL;
					end
				end
				S_DEC: begin
					if (!skip && need_mul) begin
						cur_m_q    <= mag;
						cur_rank_q <= rank;
						cstep_q    <= '0;
						state_q    <= S_CMUL;
					end else begin
						if (take) begin
							best_q  <= metric;
							brank_q <= rank;
							bmag_q  <= mag;
							bpw_q   <= pw_q;
							ref_q   <= nd_q;
							hop_q   <= cur_id_q;
							have_q  <= 1'b1;
						end
						k_q     <= k_q + KW'(1);
						state_q <= S_NEXT;
					end
				end
				S_CMUL: begin
					if (mul_stat.done) begin
						if (cstep_q == 2'd3) begin
							state_q <= S_CCMP;
						end else begin
							cstep_q <= cstep_q + 2'd1;
						end
					end
				end
				S_CCMP: begin
					if (c_take) begin
						brank_q <= cur_rank_q;
						bmag_q  <= cur_m_q;
						bpw_q   <= pw_q;
						ref_q   <= nd_q;
						hop_q   <= cur_id_q;
					end
					k_q     <= k_q + KW'(1);
					state_q <= S_NEXT;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status        <= status_q;
						rsp_q.next_hop_id   <= hop_q;
						rsp_q.removed_count <= removed_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_count_only_purge: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.removed_count == '0 || rsp.status == STATUS_PURGED))
		else $error("removed count on a non-purge transaction");

	a_hop_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STATUS_FOUND) |-> rsp.next_hop_id == '0)
		else $error("next hop set without a route");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(mem_waddr)])
		else $error("written slot not marked valid");

	a_mul_in_compass: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> state_q == S_CMUL)
		else $error("serial multiply finished outside compass compare");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp_ready) |=> state_q == S_DONE)
		else $error("result dropped while output register busy");

endmodule
`default_nettype wire

/* tb/geographic_next_hop_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geographic next-hop table testbench
// Drives hello, route and purge transactions under changing register settings
// and checks each response against a cycle-free table model or a fixed value.
// ----------------------------------------------------------------------------
module geographic_next_hop_table_top_tb;
	import gnh_pkg::*;

	localparam int SLOTS        = 32;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int STALL_LIMIT  = 100000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef logic signed [255:0] big_t;

	typedef struct {
		gnh_req_t r;
		bit       typed;
		gnh_rsp_t e;
	} vec_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	gnh_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	gnh_rsp_t rsp;
	logic     psel;
	logic     penable;
	logic     pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic     pready;

	geographic_next_hop_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// table shadow and register shadow
	bit                    nb_valid [SLOTS];
	logic [ID_BITS-1:0]    nb_id    [SLOTS];
	logic signed [COORD_BITS-1:0] nb_x [SLOTS], nb_y [SLOTS], nb_z [SLOTS];
	logic [TIME_BITS-1:0]  nb_stamp [SLOTS];
	logic [METHOD_BITS-1:0] sel_method;
	logic [TIME_BITS-1:0]  expiry;
	logic signed [COORD_BITS-1:0] own_x, own_y, own_z;

	gnh_rsp_t pending_rsp [$];
	int       err_count;
	bit       no_idle;
	int       stall_cycles;
	logic [TIME_BITS-1:0] tick;
	vec_t     dir_vec [$];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic big_t sq_dist(big_t ax, big_t ay, big_t az,
					 big_t bx, big_t by, big_t bz, bit three);
		big_t s;
		s = (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
		if (three)
			s = s + (az - bz) * (az - bz);
		return s;
	endfunction

	function automatic int cmp_big(big_t a, big_t b);
		return a < b ? -1 : (a > b ? 1 : 0);
	endfunction

	function automatic big_t abs_big(big_t a);
		return a < 0 ? -a : a;
	endfunction

	function automatic bit is_stale(int k, logic [TIME_BITS-1:0] now);
		logic [TIME_BITS-1:0] age;
		age = now - nb_stamp[k];
		return expiry != 0 && age >= expiry;
	endfunction

	// pick the next hop by the configured method; returns 0 when none
	function automatic bit pick_next_hop(gnh_req_t r, output logic [ID_BITS-1:0] hop);
		big_t sx, sy, sz, dx, dy, dz, nx, ny, nz;
		big_t d2, best, ref_d, bmag, bpw, nd, metric, m, pw, dot;
		int   bsg, sg, c;
		bit   have;
		sx = own_x; sy = own_y; sz = own_z;
		dx = r.dest_x; dy = r.dest_y; dz = r.dest_z;
		d2 = sq_dist(sx, sy, sz, dx, dy, dz, 1);
		best = d2; ref_d = d2; bmag = 0; bpw = 0; bsg = 0; have = 0; hop = '0;
		if (sel_method == METHOD_MFR && d2 == 0)
			return 0;
		if (sel_method == METHOD_COMPASS && sq_dist(sx, sy, 0, dx, dy, 0, 0) == 0)
			return 0;
		for (int k = 0; k < SLOTS; k++) begin
			if (!nb_valid[k] || is_stale(k, r.now))
				continue;
			nx = nb_x[k]; ny = nb_y[k]; nz = nb_z[k];
			nd = sq_dist(nx, ny, nz, dx, dy, dz, 1);
			metric = 0; m = 0; pw = 0; sg = 0;
			case (sel_method)
				METHOD_GREEDY: begin
					metric = nd;
					c = cmp_big(metric, best);
				end
				METHOD_NFP: begin
					if (nd > d2)
						continue;
					metric = sq_dist(nx, ny, nz, sx, sy, sz, 1);
					c = cmp_big(metric, best);
				end
				METHOD_MFR: begin
					dot = (nx - sx) * (dx - sx) + (ny - sy) * (dy - sy)
						+ (nz - sz) * (dz - sz);
					metric = abs_big(d2 - dot);
					c = cmp_big(metric, best);
				end
				default: begin
					pw = sq_dist(nx, ny, 0, sx, sy, 0, 0);
					if (pw == 0)
						continue;
					dot = (nx - sx) * (dx - sx) + (ny - sy) * (dy - sy);
					sg = dot > 0 ? 1 : (dot < 0 ? -1 : 0);
					m = abs_big(dot);
					if (!have)
						c = -1;
					else if (sg != bsg)
						c = sg > bsg ? -1 : 1;
					else if (sg == 0)
						c = 0;
					else begin
						c = cmp_big(m * m * bpw, bmag * bmag * pw);
						if (sg > 0)
							c = -c;
					end
				end
			endcase
			if (c < 0 || (c == 0 && nd < ref_d)) begin
				best = metric; bsg = sg; bmag = m; bpw = pw; ref_d = nd;
				hop = nb_id[k];
				have = 1;
			end
		end
		return have;
	endfunction

	// apply one command to the shadow table and form its response
	task automatic table_apply(input gnh_req_t r, output bit has, output gnh_rsp_t o);
		int slot;
		logic [ID_BITS-1:0] hop;
		o = '0;
		has = 1;
		case (r.command)
			CMD_HELLO: begin
				slot = -1;
				o.status = STATUS_FULL;
				for (int k = 0; k < SLOTS; k++)
					if (slot < 0 && nb_valid[k] && nb_id[k] == r.neighbor_id) begin
						slot = k;
						o.status = STATUS_UPDATED;
					end
				for (int k = 0; k < SLOTS; k++)
					if (slot < 0 && !nb_valid[k]) begin
						slot = k;
						o.status = STATUS_INSERTED;
					end
				if (slot >= 0) begin
					nb_valid[slot] = 1;
					nb_id[slot]    = r.neighbor_id;
					nb_x[slot]     = r.nbr_x;
					nb_y[slot]     = r.nbr_y;
					nb_z[slot]     = r.nbr_z;
					nb_stamp[slot] = r.now;
				end
			end
			CMD_ROUTE: begin
				if (pick_next_hop(r, hop)) begin
					o.status = STATUS_FOUND;
					o.next_hop_id = hop;
				end else
					o.status = STATUS_NO_ROUTE;
			end
			CMD_PURGE: begin
				o.status = STATUS_PURGED;
				for (int k = 0; k < SLOTS; k++)
					if (nb_valid[k] && is_stale(k, r.now)) begin
						nb_valid[k] = 0;
						if (o.removed_count != COUNT_MAX)
							o.removed_count = o.removed_count + 1'b1;
					end
			end
			default: has = 0;
		endcase
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = ADDR_BITS'(idx) << 3; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_METHOD: sel_method = val[METHOD_BITS-1:0];
			REG_EXPIRY: expiry     = val[TIME_BITS-1:0];
			REG_SELF_X: own_x      = val[COORD_BITS-1:0];
			REG_SELF_Y: own_y      = val[COORD_BITS-1:0];
			REG_SELF_Z: own_z      = val[COORD_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	// send one transaction; valid stays up until accepted
	task automatic send(input gnh_req_t r, input bit typed, input gnh_rsp_t e);
		bit has;
		gnh_rsp_t o;
		while (!no_idle && $urandom_range(0, 99) < 20) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		table_apply(r, has, o);
		if (typed)
			o = e;
		if (has)
			pending_rsp.push_back(o);
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2: return COORD_BITS'($signed($urandom_range(0, 6)) - 3);
			3, 4, 5: return COORD_BITS'($signed($urandom_range(0, 4000)) - 2000);
			6, 7:    return COORD_BITS'($urandom);
			default: return $urandom_range(0, 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
							     : {1'b1, {(COORD_BITS-1){1'b0}}};
		endcase
	endfunction

	function automatic gnh_req_t rand_req();
		gnh_req_t r;
		int pick;
		r.now = tick;
		if ($urandom_range(0, 99) < 3)
			r.now = TIME_BITS'({$urandom, $urandom});
		r.neighbor_id = $urandom_range(0, 99) < 85 ? ID_BITS'($urandom_range(0, 47))
							  : ID_BITS'($urandom);
		r.nbr_x = rand_coord(); r.nbr_y = rand_coord(); r.nbr_z = rand_coord();
		r.dest_x = rand_coord(); r.dest_y = rand_coord(); r.dest_z = rand_coord();
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.command = CMD_HELLO;
		else if (pick < 85)
			r.command = CMD_ROUTE;
		else if (pick < 97)
			r.command = CMD_PURGE;
		else
			r.command = CMD_UNUSED;
		return r;
	endfunction

	function automatic vec_t row(logic [1:0] cmd, logic [TIME_BITS-1:0] now,
				     logic [ID_BITS-1:0] id, logic signed [COORD_BITS-1:0] n,
				     logic signed [COORD_BITS-1:0] d, bit typed,
				     logic [STATUS_BITS-1:0] st, logic [COUNT_BITS-1:0] cnt);
		vec_t v;
		v.r.command = cmd; v.r.now = now; v.r.neighbor_id = id;
		v.r.nbr_x = n; v.r.nbr_y = n; v.r.nbr_z = n;
		v.r.dest_x = d; v.r.dest_y = d; v.r.dest_z = d;
		v.typed = typed;
		v.e.status = st; v.e.next_hop_id = '0; v.e.removed_count = cnt;
		return v;
	endfunction

	// response checker
	always @(posedge clk) begin
		gnh_rsp_t x;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response status=%0d", rsp.status);
				err_count++;
			end else begin
				x = pending_rsp.pop_front();
				if (rsp.status !== x.status) begin
					$error("status: expected %0d, got %0d", x.status, rsp.status);
					err_count++;
				end
				if (rsp.next_hop_id !== x.next_hop_id) begin
					$error("next_hop_id: expected %0d, got %0d",
						x.next_hop_id, rsp.next_hop_id);
					err_count++;
				end
				if (rsp.removed_count !== x.removed_count) begin
					$error("removed_count: expected %0d, got %0d",
						x.removed_count, rsp.removed_count);
					err_count++;
				end
			end
		end
	end

	always @(negedge clk)
		rsp_ready <= no_idle || $urandom_range(0, 99) >= 20;

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		logic signed [COORD_BITS-1:0] cmax, cmin;
		logic [TIME_BITS-1:0] tmax, exp_sel;
		logic signed [COORD_BITS-1:0] sx;
		gnh_rsp_t none;
		cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
		cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
		tmax = {TIME_BITS{1'b1}};
		none = '0;
		arst_n = 1'b0; req_valid = 1'b0; req = '0; rsp_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		err_count = 0; no_idle = 0; tick = '0;
		foreach (nb_valid[k]) nb_valid[k] = 0;
		sel_method = METHOD_GREEDY; expiry = EXPIRY_RESET;
		own_x = '0; own_y = '0; own_z = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		dir_vec.push_back(row(CMD_ROUTE, 0, 0, 0, 0, 1, STATUS_NO_ROUTE, 0));
		dir_vec.push_back(row(CMD_PURGE, 0, 0, 0, 0, 1, STATUS_PURGED, 0));
		dir_vec.push_back(row(CMD_HELLO, 0, 16'h0000, cmax, 0, 1, STATUS_INSERTED, 0));
		dir_vec.push_back(row(CMD_HELLO, 1, 16'hFFFF, cmin, 0, 1, STATUS_INSERTED, 0));
		dir_vec.push_back(row(CMD_HELLO, 2, 16'h0000, 256, 0, 1, STATUS_UPDATED, 0));
		dir_vec.push_back(row(CMD_HELLO, tmax, 16'h1234, -512, 0, 1,
			STATUS_INSERTED, 0));
		dir_vec.push_back(row(CMD_ROUTE, 10, 0, 0, cmax, 0, 0, 0));
		dir_vec.push_back(row(CMD_ROUTE, 10, 0, 0, cmin, 0, 0, 0));
		dir_vec.push_back(row(CMD_ROUTE, 10, 0, 0, 0, 1, STATUS_NO_ROUTE, 0));
		dir_vec.push_back(row(CMD_UNUSED, 10, 0, 0, 0, 0, 0, 0));
		dir_vec.push_back(row(CMD_PURGE, 48'd2500000002, 0, 0, 0, 1, STATUS_PURGED, 3));
		dir_vec.push_back(row(CMD_ROUTE, 48'd2500000002, 0, 0, 5, 1,
			STATUS_NO_ROUTE, 0));
		dir_vec.push_back(row(CMD_HELLO, tmax, 16'h0007, 1000, 0, 1, STATUS_INSERTED, 0));
		dir_vec.push_back(row(CMD_ROUTE, 5, 0, 0, 900, 0, 0, 0));
		dir_vec.push_back(row(CMD_ROUTE, 5, 0, 0, 3000, 0, 0, 0));
		foreach (dir_vec[i])
			send(dir_vec[i].r, dir_vec[i].typed, dir_vec[i].e);
		wait_drained();
		repeat (20) @(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: exp_sel = '0;
				1: exp_sel = 48'd40;
				2: exp_sel = tmax;
				3: exp_sel = $urandom_range(20, 200);
				4: exp_sel = 48'd1;
				5: exp_sel = '0;
				6: exp_sel = EXPIRY_RESET;
				default: exp_sel = 48'd100;
			endcase
			reg_write(REG_METHOD, DATA_BITS'(ph % 4));
			reg_write(REG_EXPIRY, DATA_BITS'(exp_sel));
			for (int a = 0; a < 3; a++) begin
				case (ph)
					0: sx = '0;
					1: sx = cmax;
					2: sx = cmin;
					default: sx = rand_coord();
				endcase
				reg_write(REG_SELF_X + 3'(a), {{(DATA_BITS-COORD_BITS){sx[COORD_BITS-1]}}, sx});
			end
			no_idle = (ph == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 2 && i == PHASE_ITEMS / 2)
					wait_drained();
				if (ph == 6 && $urandom_range(0, 9) == 0)
					tick = tick + {$urandom_range(0, 3), $urandom};
				else
					tick = tick + $urandom_range(0, 8);
				send(rand_req(), 0, none);
			end
			wait_drained();
			repeat (20) @(negedge clk);
		end

		no_idle = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/gnh_pkg.sv
design/gnh_serial_mul.sv
design/geographic_next_hop_table_top.sv
tb/geographic_next_hop_table_top_tb.sv
